// ----- rtl/qmm_pkg.sv -----
// Package for the quad motor mixer: widths, codes, state type, the
// inverse-entry recipe table and the controller/datapath command structs.
// No dependencies.
package qmm_pkg;

    localparam int DATA_W  = 32;   // Q16.16 data word
    localparam int GEO_W   = 24;   // Q4.20 geometry register
    localparam int SUM_W   = GEO_W + 1;
    localparam int CW_W    = GEO_W + SUM_W;   // ratio * arm sum
    localparam int COEF_W  = 40;   // Q20.20 cached inverse, also holds Q4.20
    localparam int XPART_W = 17;   // signed half of a data word
    localparam int PROD_W  = COEF_W + XPART_W;
    localparam int ACC_W   = 75;
    localparam int NUM_W   = 64;   // divider dividend
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int INV_AW  = 4;

    localparam logic [COEF_W-1:0] INV_MAX = {1'b0, {(COEF_W-1){1'b1}}};

    // reset values of the geometry registers
    localparam logic [GEO_W-1:0] ARM_RST = 24'd104858;
    localparam logic [GEO_W-1:0] YAW_RST = 24'd16777;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SING = 2'd2;

    // operation codes
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYOUT = 3'd0,
        CFG_FX     = 3'd1,
        CFG_FY     = 3'd2,
        CFG_BX     = 3'd3,
        CFG_BY     = 3'd4,
        CFG_YAW    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DONE
    } t_state;

    // kinds of closed-form inverse entries
    typedef enum logic [1:0] {
        K_RT,   // arm / arm sum
        K_UT,   // 1 / arm sum
        K_CT    // arm / (ratio * arm sum)
    } t_kind;

    typedef enum logic [1:0] {
        G_FX,
        G_FY,
        G_BX,
        G_BY
    } t_geo;

    typedef enum logic {
        AX_X,
        AX_Y
    } t_axis;

    typedef struct packed {
        t_kind kind;
        t_geo  num;
        t_axis den;
        logic  neg;
    } t_entry;

    typedef struct packed {
        logic              capture;
        logic              mac_en;
        logic              mac_hi;
        logic [1:0]        mac_row;
        logic [1:0]        mac_col;
        logic              row_start;
        logic              row_end;
        logic              div_start;
        logic              inv_wr;
        logic [INV_AW-1:0] inv_idx;
        logic              out_load;
        logic              out_sing;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic singular;
        logic div_done;
    } t_stat;

    // Recipe for inverse entry idx (row = motor, col = thrust/roll/pitch/yaw)
    function automatic t_entry inv_entry(input logic layout, input logic [INV_AW-1:0] idx);
        t_entry     e;
        logic [1:0] row;
        logic [1:0] col;
        row = idx[3:2];
        col = idx[1:0];
        e.kind = K_UT;
        e.num  = G_FX;
        e.den  = AX_Y;
        e.neg  = 1'b0;
        if (layout == 1'b0) begin
            case (col)
                2'd0: begin
                    e.kind = K_RT;
                    e.num  = row[0] ? G_FY : G_BY;
                    e.den  = AX_Y;
                end
                2'd1: begin
                    e.den = AX_Y;
                    e.neg = ~row[0];
                end
                2'd2: begin
                    e.den = AX_X;
                    e.neg = (row == 2'd0) || (row == 2'd3);
                end
                default: begin
                    e.kind = K_CT;
                    e.num  = row[0] ? G_FX : G_BX;
                    e.den  = AX_X;
                    e.neg  = ~row[1];
                end
            endcase
        end else begin
            case (col)
                2'd0: begin
                    e.kind = K_RT;
                    e.num  = row[0] ? G_BX : G_FX;
                    e.den  = AX_X;
                end
                2'd1: begin
                    e.den = AX_Y;
                    e.neg = ~row[1];
                end
                2'd2: begin
                    e.den = AX_X;
                    e.neg = row[0];
                end
                default: begin
                    e.kind = K_CT;
                    e.num  = row[0] ? G_BY : G_FY;
                    e.den  = AX_Y;
                    e.neg  = (row == 2'd1) || (row == 2'd2);
                end
            endcase
        end
        return e;
    endfunction

endpackage

// ----- rtl/quad_motor_mixer_unit.sv -----
// Top level of the quad motor mixer: stream ports, configuration port,
// controller and datapath. Depends on qmm_pkg, qmm_ctrl, qmm_datapath.
//
// Quadrotor control allocation. tuser 0 maps four motor thrusts to
// collective thrust, roll, pitch and yaw torque; tuser 1 maps thrust and
// torques back to motor thrusts through the inverse of the allocation
// matrix. Data is signed Q16.16, geometry unsigned Q4.20. One request is
// worked at a time on a single 40x17 multiplier, which steps through the
// matrix entries; the row sums are then rounded, clamped and registered.
// The first inverse request after reset or after a write to a geometry or
// layout register (index 0 to 5) also rebuilds the cached inverse, 16
// entries by bit-serial division, unless the matrix is singular. A result
// waits in the output register while the next request is taken. Status 1
// means some output was clamped, 2 that the matrix is singular (outputs zero).
module quad_motor_mixer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [127:0]                  i_s_tdata,   // in_a, in_b, in_c, in_d
    input  logic                          i_s_tuser,   // op
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [127:0]                  o_m_tdata,   // out_a, out_b, out_c, out_d
    output logic [qmm_pkg::STAT_W-1:0]    o_m_tuser,   // status
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qmm_pkg::GEO_W-1:0]     i_cfg_data
);
    import qmm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    qmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    qmm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_data      (o_m_tdata),
        .o_status    (o_m_tuser)
    );

endmodule

// ----- rtl/qmm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, rounding
// the quotient to nearest by adding half the divisor up front.
// Depends on qmm_pkg.
module qmm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qmm_pkg::NUM_W-1:0]   i_num,
    input  logic [qmm_pkg::CW_W-1:0]    i_den,
    output logic                        o_done,
    output logic [qmm_pkg::NUM_W-1:0]   o_quot
);
    import qmm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CW_W:0]    r_rem;
    logic [NUM_W-1:0] r_q;
    logic [CW_W-1:0]  r_den;

    logic [CW_W:0] shifted;
    logic [CW_W:0] diff;
    logic          take;

    // trial subtract of one step
    always_comb begin
        shifted = {r_rem[CW_W-1:0], r_q[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        take    = (shifted >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num + NUM_W'(i_den >> 1);
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? diff : shifted;
            r_q   <= {r_q[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/qmm_ctrl.sv -----
// Sequencer of the mixer: accepts requests, rebuilds the cached inverse
// when needed, steps the shared multiplier and hands results out.
// Depends on qmm_pkg.
module qmm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_valid,
    input  logic [qmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  qmm_pkg::t_stat                i_stat,
    output qmm_pkg::t_cmd                 o_cmd
);
    import qmm_pkg::*;

    t_state            r_state, n_state;
    logic [4:0]        r_step, n_step;
    logic [INV_AW-1:0] r_ent, n_ent;
    logic              r_inv_vld, n_inv_vld;
    logic              r_sing, n_sing;
    logic              r_out_vld, n_out_vld;
    t_cmd              cmd;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_ent     <= '0;
            r_inv_vld <= 1'b0;
            r_sing    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_ent     <= n_ent;
            r_inv_vld <= n_inv_vld;
            r_sing    <= n_sing;
            r_out_vld <= n_out_vld;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_ent     = r_ent;
        n_inv_vld = r_inv_vld;
        n_sing    = r_sing;
        n_out_vld = r_out_vld;
        cmd       = '0;
        cmd.mac_hi    = r_step[0];
        cmd.mac_col   = r_step[2:1];
        cmd.mac_row   = r_step[4:3];
        cmd.row_start = (r_step[2:0] == 3'd0);
        cmd.row_end   = (r_step[2:0] == 3'd7);
        cmd.inv_idx   = r_ent;
        cmd.out_sing  = r_sing;

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.capture = 1'b1;
                    n_sing      = 1'b0;
                    n_state     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_step = '0;
                n_ent  = '0;
                if (i_stat.op == OP_FWD || r_inv_vld) begin
                    n_state = ST_MAC;
                end else if (i_stat.singular) begin
                    n_sing  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                n_state       = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.inv_wr = 1'b1;
                    n_ent      = r_ent + 1'b1;
                    if (r_ent == INV_AW'(15)) begin
                        n_inv_vld = 1'b1;
                        n_state   = ST_MAC;
                    end else begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_MAC: begin
                cmd.mac_en = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == 5'd31) begin
                    n_state = ST_DRAIN1;
                end
            end
            ST_DRAIN1: begin
                n_state = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    cmd.out_load = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a write to any geometry or layout register drops the cached inverse
        if (i_cfg_valid && i_cfg_index <= CFG_YAW) begin
            n_inv_vld = 1'b0;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_cmd      = cmd;

endmodule

// ----- rtl/qmm_datapath.sv -----
// Datapath of the mixer: configuration registers, cached inverse,
// shared 40x17 multiply-accumulate with rounding and clamping, and the
// operand setup for the divider. Depends on qmm_pkg and qmm_div.
module qmm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [qmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qmm_pkg::GEO_W-1:0]     i_cfg_data,
    input  logic                          i_op,
    input  logic [4*qmm_pkg::DATA_W-1:0]  i_data,
    input  qmm_pkg::t_cmd                 i_cmd,
    output qmm_pkg::t_stat                o_stat,
    output logic [4*qmm_pkg::DATA_W-1:0]  o_data,
    output logic [qmm_pkg::STAT_W-1:0]    o_status
);
    import qmm_pkg::*;

    // configuration
    logic             r_layout;
    logic [GEO_W-1:0] r_fx, r_fy, r_bx, r_by, r_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= 1'b0;
            r_fx     <= ARM_RST;
            r_fy     <= ARM_RST;
            r_bx     <= ARM_RST;
            r_by     <= ARM_RST;
            r_yaw    <= YAW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAYOUT: r_layout <= i_cfg_data[0];
                CFG_FX:     r_fx     <= i_cfg_data;
                CFG_FY:     r_fy     <= i_cfg_data;
                CFG_BX:     r_bx     <= i_cfg_data;
                CFG_BY:     r_by     <= i_cfg_data;
                CFG_YAW:    r_yaw    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // arm sums and ratio products
    logic [SUM_W-1:0] sx, sy;
    logic [CW_W-1:0]  r_cwx, r_cwy;

    assign sx = SUM_W'(r_fx) + SUM_W'(r_bx);
    assign sy = SUM_W'(r_fy) + SUM_W'(r_by);

    always_ff @(posedge i_clk) begin
        r_cwx <= r_yaw * sx;
        r_cwy <= r_yaw * sy;
    end

    // captured request
    logic              r_op;
    logic [DATA_W-1:0] r_x [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            for (int i = 0; i < 4; i++) begin
                r_x[i] <= i_data[i*DATA_W +: DATA_W];
            end
        end
    end

    // divider operands for the current inverse entry
    t_entry           ent;
    logic [GEO_W-1:0] geo;
    logic [SUM_W-1:0] wsum;
    logic [NUM_W-1:0] div_num;
    logic [CW_W-1:0]  div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    always_comb begin
        ent = inv_entry(r_layout, i_cmd.inv_idx);
        case (ent.num)
            G_FX:    geo = r_fx;
            G_FY:    geo = r_fy;
            G_BX:    geo = r_bx;
            default: geo = r_by;
        endcase
        wsum = (ent.den == AX_X) ? sx : sy;
        case (ent.kind)
            K_RT: begin
                div_num = NUM_W'({geo, 19'b0});
                div_den = CW_W'(wsum);
            end
            K_CT: begin
                div_num = NUM_W'({geo, 39'b0});
                div_den = (ent.den == AX_X) ? r_cwx : r_cwy;
            end
            default: begin
                div_num = NUM_W'(1) << 39;
                div_den = CW_W'(wsum);
            end
        endcase
    end

    qmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // cached inverse, Q20.20; sign of the entry held with the write index
    logic [COEF_W-1:0] r_inv [16];
    logic [COEF_W-1:0] inv_mag;

    assign inv_mag = (|div_quot[NUM_W-1:COEF_W-1]) ? INV_MAX : div_quot[COEF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.inv_wr) begin
            r_inv[i_cmd.inv_idx] <= ent.neg ? (~inv_mag + 1'b1) : inv_mag;
        end
    end

    // forward coefficient, Q4.20
    logic signed [COEF_W-1:0] pfx, pfy, pbx, pby, pc, fwd;

    always_comb begin
        pfx = COEF_W'(r_fx);
        pfy = COEF_W'(r_fy);
        pbx = COEF_W'(r_bx);
        pby = COEF_W'(r_by);
        pc  = COEF_W'(r_yaw);
        fwd = COEF_W'(1) << 20;
        case ({r_layout, i_cmd.mac_row})
            3'b001: case (i_cmd.mac_col)
                2'd0, 2'd2: fwd = -pfy;
                default:    fwd = pby;
            endcase
            3'b010: case (i_cmd.mac_col)
                2'd0:    fwd = -pfx;
                2'd1:    fwd = pbx;
                2'd2:    fwd = pfx;
                default: fwd = -pbx;
            endcase
            3'b011: fwd = i_cmd.mac_col[1] ? pc : -pc;
            3'b101: case (i_cmd.mac_col)
                2'd0:    fwd = -pby;
                2'd1:    fwd = -pfy;
                2'd2:    fwd = pby;
                default: fwd = pfy;
            endcase
            3'b110: fwd = i_cmd.mac_col[0] ? -pfx : pbx;
            3'b111: fwd = (i_cmd.mac_col == 2'd0 || i_cmd.mac_col == 2'd3) ? pc : -pc;
            default: ;
        endcase
    end

    // multiply stage
    logic signed [COEF_W-1:0]  coef;
    logic [DATA_W-1:0]         xsel;
    logic signed [XPART_W-1:0] xpart;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_p_vld, r_p_hi, r_p_start, r_p_end;
    logic [1:0]                r_p_row;

    always_comb begin
        coef  = (r_op == OP_INV) ? r_inv[{i_cmd.mac_row, i_cmd.mac_col}] : fwd;
        xsel  = r_x[i_cmd.mac_col];
        xpart = i_cmd.mac_hi ? {xsel[DATA_W-1], xsel[DATA_W-1:16]} : {1'b0, xsel[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.mac_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= coef * xpart;
        r_p_hi    <= i_cmd.mac_hi;
        r_p_start <= i_cmd.row_start;
        r_p_end   <= i_cmd.row_end;
        r_p_row   <= i_cmd.mac_row;
    end

    // accumulate stage
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] addend;
    logic                    r_fin_vld;
    logic [1:0]              r_fin_row;

    assign addend = r_p_hi ? (ACC_W'(r_prod) <<< 16) : ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else begin
            r_fin_vld <= r_p_vld && r_p_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc <= (r_p_start ? '0 : r_acc) + addend;
        end
        r_fin_row <= r_p_row;
    end

    // round to nearest (ties up), clamp to 32 bits
    logic signed [ACC_W-1:0] rnd;
    logic                    ovf_hi, ovf_lo;
    logic [DATA_W-1:0]       fin;
    logic [DATA_W-1:0]       r_res [4];
    logic                    r_sat;

    always_comb begin
        rnd    = (r_acc + (ACC_W'(1) <<< 19)) >>> 20;
        ovf_hi = (rnd > $signed(ACC_W'(32'h7FFF_FFFF)));
        ovf_lo = (rnd < -$signed(ACC_W'(33'h1_0000_0000) >>> 1));
        if (ovf_hi) begin
            fin = 32'h7FFF_FFFF;
        end else if (ovf_lo) begin
            fin = 32'h8000_0000;
        end else begin
            fin = rnd[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin_vld) begin
            r_res[r_fin_row] <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.capture) begin
            r_sat <= 1'b0;
        end else if (r_fin_vld && (ovf_hi || ovf_lo)) begin
            r_sat <= 1'b1;
        end
    end

    // output register
    logic [4*DATA_W-1:0] r_out;
    logic [STAT_W-1:0]   r_out_stat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_sing) begin
                r_out      <= '0;
                r_out_stat <= STAT_SING;
            end else begin
                r_out      <= {r_res[3], r_res[2], r_res[1], r_res[0]};
                r_out_stat <= r_sat ? STAT_SAT : STAT_OK;
            end
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.singular = (r_yaw == '0) || (sx == '0) || (sy == '0);
    assign o_stat.div_done = div_done;
    assign o_data          = r_out;
    assign o_status        = r_out_stat;

endmodule

// ----- test/quad_motor_mixer_unit_tb.sv -----
// Testbench for quad_motor_mixer_unit: forward and inverse mixing across motor layouts,
// geometry extremes, singular and clamped cases, with random gaps and stalls on both sides.
// Depends on qmm_pkg and quad_motor_mixer_unit.
module quad_motor_mixer_unit_tb;
    import qmm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint ONE_Q20 = 64'sd1 << 20;
    localparam longint COEF_MAX = (64'sd1 << 39) - 1;
    localparam longint unsigned UNIT_NUM = 64'd1 << 39;

    typedef struct packed {
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] a;
        logic [STAT_W-1:0] st;
    } t_mix_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [127:0]          i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [127:0]          o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [GEO_W-1:0]      i_cfg_data;

    quad_motor_mixer_unit DUT (.*);

    // predictor state
    logic             geo_layout;
    longint unsigned  geo_fx, geo_fy, geo_bx, geo_by, geo_yaw;
    longint           inv_coef [16];
    bit               inv_cached;

    t_mix_out expected_mix [$];
    int       mismatches;
    bit       no_gaps;
    int       hold_cycles;
    int       stall_left;

    // clock and single reset
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 2000000);
        $display("quad_motor_mixer_unit_tb NOT OK");
        $finish;
    end

    // Q20.20 ratio, rounded half away from zero, magnitude clamped
    function automatic longint q20_ratio(longint unsigned n, longint unsigned d, bit neg);
        longint unsigned m;
        longint          v;
        m = (n + (d >> 1)) / d;
        v = (m > longint'(COEF_MAX)) ? COEF_MAX : longint'(m);
        return neg ? -v : v;
    endfunction

    function automatic bit rebuild_inverse();
        longint unsigned sy, sx, c;
        longint unsigned fx, fy, bx, by;
        fx = geo_fx; fy = geo_fy; bx = geo_bx; by = geo_by; c = geo_yaw;
        sy = fy + by;
        sx = fx + bx;
        if (c == 0 || sy == 0 || sx == 0) return 1'b0;
        if (geo_layout == 1'b0) begin
            inv_coef[0]  = q20_ratio(by << 19, sy, 0);  inv_coef[1]  = q20_ratio(UNIT_NUM, sy, 1);
            inv_coef[2]  = q20_ratio(UNIT_NUM, sx, 1);  inv_coef[3]  = q20_ratio(bx << 39, c*sx, 1);
            inv_coef[4]  = q20_ratio(fy << 19, sy, 0);  inv_coef[5]  = q20_ratio(UNIT_NUM, sy, 0);
            inv_coef[6]  = q20_ratio(UNIT_NUM, sx, 0);  inv_coef[7]  = q20_ratio(fx << 39, c*sx, 1);
            inv_coef[8]  = q20_ratio(by << 19, sy, 0);  inv_coef[9]  = q20_ratio(UNIT_NUM, sy, 1);
            inv_coef[10] = q20_ratio(UNIT_NUM, sx, 0);  inv_coef[11] = q20_ratio(bx << 39, c*sx, 0);
            inv_coef[12] = q20_ratio(fy << 19, sy, 0);  inv_coef[13] = q20_ratio(UNIT_NUM, sy, 0);
            inv_coef[14] = q20_ratio(UNIT_NUM, sx, 1);  inv_coef[15] = q20_ratio(fx << 39, c*sx, 0);
        end else begin
            inv_coef[0]  = q20_ratio(fx << 19, sx, 0);  inv_coef[1]  = q20_ratio(UNIT_NUM, sy, 1);
            inv_coef[2]  = q20_ratio(UNIT_NUM, sx, 0);  inv_coef[3]  = q20_ratio(fy << 39, c*sy, 0);
            inv_coef[4]  = q20_ratio(bx << 19, sx, 0);  inv_coef[5]  = q20_ratio(UNIT_NUM, sy, 1);
            inv_coef[6]  = q20_ratio(UNIT_NUM, sx, 1);  inv_coef[7]  = q20_ratio(by << 39, c*sy, 1);
            inv_coef[8]  = q20_ratio(fx << 19, sx, 0);  inv_coef[9]  = q20_ratio(UNIT_NUM, sy, 0);
            inv_coef[10] = q20_ratio(UNIT_NUM, sx, 0);  inv_coef[11] = q20_ratio(fy << 39, c*sy, 1);
            inv_coef[12] = q20_ratio(bx << 19, sx, 0);  inv_coef[13] = q20_ratio(UNIT_NUM, sy, 0);
            inv_coef[14] = q20_ratio(UNIT_NUM, sx, 1);  inv_coef[15] = q20_ratio(by << 39, c*sy, 0);
        end
        return 1'b1;
    endfunction

    // one matrix row times the input vector, rounded half up, clamped
    function automatic logic [DATA_W-1:0] mix_row(input longint coef [4], input longint x [4],
                                                  inout bit sat);
        longint hi, lo, k, r, res;
        hi = 0;
        lo = 0;
        for (int j = 0; j < 4; j++) begin
            hi += coef[j] * (x[j] >>> 16);
            lo += coef[j] * (x[j] & 64'hFFFF);
        end
        k = hi + (lo >>> 16);
        r = (lo & 64'hFFFF) + (64'sd1 << 19);
        k += r >>> 16;
        res = k >>> 4;
        if (res > 64'sd2147483647) begin res = 64'sd2147483647; sat = 1'b1; end
        if (res < -64'sd2147483648) begin res = -64'sd2147483648; sat = 1'b1; end
        return res[DATA_W-1:0];
    endfunction

    function automatic t_mix_out predict_mix(logic op, logic [127:0] data);
        longint   x [4];
        longint   m [16];
        longint   row [4];
        longint   fx, fy, bx, by, c;
        bit       sat;
        logic [DATA_W-1:0] r [4];
        t_mix_out o;
        for (int i = 0; i < 4; i++) x[i] = longint'($signed(data[32*i +: 32]));
        fx = geo_fx; fy = geo_fy; bx = geo_bx; by = geo_by; c = geo_yaw;
        o = '0;
        if (op == OP_FWD) begin
            for (int j = 0; j < 4; j++) m[j] = ONE_Q20;
            if (geo_layout == 1'b0) begin
                m[4] = -fy; m[5] = by;  m[6] = -fy; m[7] = by;
                m[8] = -fx; m[9] = bx;  m[10] = fx; m[11] = -bx;
                m[12] = -c; m[13] = -c; m[14] = c;  m[15] = c;
            end else begin
                m[4] = -by; m[5] = -fy; m[6] = by;  m[7] = fy;
                m[8] = bx;  m[9] = -fx; m[10] = bx; m[11] = -fx;
                m[12] = c;  m[13] = -c; m[14] = -c; m[15] = c;
            end
        end else begin
            if (!inv_cached) inv_cached = rebuild_inverse();
            if (!inv_cached) begin
                o.st = STAT_SING;
                return o;
            end
            m = inv_coef;
        end
        sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) row[j] = m[4*i + j];
            r[i] = mix_row(row, x, sat);
        end
        o.a = r[0]; o.b = r[1]; o.c = r[2]; o.d = r[3];
        o.st = sat ? STAT_SAT : STAT_OK;
        return o;
    endfunction

    // result side: random stalls, long hold-offs on request, compare each result
    always @(posedge i_clk) begin
        t_mix_out got, want;
        int       stall_draw;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[127:96], o_m_tdata[95:64], o_m_tdata[63:32], o_m_tdata[31:0],
                       o_m_tuser};
                if (expected_mix.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_mix.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected a=%h b=%h c=%h d=%h st=%0d, ",
                                      "got a=%h b=%h c=%h d=%h st=%0d"},
                                     want.a, want.b, want.c, want.d, want.st,
                                     got.a, got.b, got.c, got.d, got.st);
                    end
                end
                stall_draw = no_gaps ? 0 : $urandom_range(0, 10);
                stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
                i_m_tready <= (stall_draw == 0 && hold_cycles == 0);
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // send one request; tvalid stays high when the next one follows with no gap
    task automatic send_mix(logic op, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {d, c, b, a};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        expected_mix.push_back(predict_mix(op, {d, c, b, a}));
    endtask

    task automatic wait_idle();
        if (i_s_tvalid) i_s_tvalid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GEO_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_LAYOUT: geo_layout = val[0];
            CFG_FX:     geo_fx = val;
            CFG_FY:     geo_fy = val;
            CFG_BX:     geo_bx = val;
            CFG_BY:     geo_by = val;
            CFG_YAW:    geo_yaw = val;
            default: ;
        endcase
        if (idx <= CFG_YAW) inv_cached = 1'b0;
    endtask

    task automatic set_geometry(logic layout, logic [23:0] fx, logic [23:0] fy,
                                logic [23:0] bx, logic [23:0] by, logic [23:0] yaw);
        wait_idle();
        write_reg(CFG_LAYOUT, {23'd0, layout});
        write_reg(CFG_FX, fx);
        write_reg(CFG_FY, fy);
        write_reg(CFG_BX, bx);
        write_reg(CFG_BY, by);
        write_reg(CFG_YAW, yaw);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2:    return $urandom_range(0, 2 << 20) - (1 << 20);
            3:       return $urandom_range(0, 1 << 17) - (1 << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 40) == 0) no_gaps = ~no_gaps;
            send_mix(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
                     rand_word());
        end
        no_gaps = 1'b0;
    endtask

    // directed: field extremes with reset geometry, both operations
    task automatic test_reset_extremes();
        send_mix(OP_FWD, 0, 0, 0, 0);
        send_mix(OP_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_mix(OP_FWD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_mix(OP_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_mix(OP_FWD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_mix(OP_INV, 32'h0004_0000, 0, 0, 0);
        send_mix(OP_INV, 0, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_0100);
        send_mix(OP_INV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_mix(OP_INV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_mix(OP_INV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
        send_mix(OP_INV, 0, 0, 0, 0);
        send_mix(OP_FWD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000);
    endtask

    // geometry sweep: layouts, extremes, singular and clamped inverse
    task automatic test_geometry_sweep();
        set_geometry(1, 104858, 104858, 104858, 104858, 16777);
        send_random(90);
        set_geometry(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_random(80);
        set_geometry(1, 1, 1, 1, 1, 1);
        send_random(80);
        set_geometry(0, 24'hFFFFFF, 1, 1, 24'hFFFFFF, 1);
        send_random(80);
        // ratio zero: singular
        set_geometry(0, 200000, 150000, 90000, 120000, 0);
        send_random(40);
        // both y offsets zero: singular
        set_geometry(1, 200000, 0, 90000, 0, 30000);
        send_random(40);
        // both x offsets zero: singular
        set_geometry(0, 0, 100000, 0, 100000, 30000);
        send_random(30);
        // one zero offset on each axis: inverse entries clamp
        set_geometry(0, 0, 100000, 300000, 0, 1);
        send_random(60);
        set_geometry(1, 0, 100000, 300000, 0, 24'hFFFFFF);
        send_random(60);
        // writes to unused indexes leave the cache alone
        wait_idle();
        write_reg(CFG_SPARE_LO, 24'hABCDEF);
        write_reg(CFG_SPARE_HI, 24'h123456);
        send_random(30);
        for (int p = 0; p < 4; p++) begin
            set_geometry(1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom));
            send_random(60);
        end
        // single register change mid-run
        wait_idle();
        write_reg(CFG_YAW, 24'($urandom_range(1, 24'hFFFFFF)));
        send_random(40);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        wait_idle();
        hold_cycles = 400;
        no_gaps = 1'b1;
        for (int n = 0; n < 30; n++)
            send_mix(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
                     rand_word());
        no_gaps = 1'b0;
    endtask

    task automatic test_random_mix();
        set_geometry(0, 104858, 104858, 104858, 104858, 16777);
        send_random(200);
        set_geometry(1, 24'($urandom_range(1, 500000)), 24'($urandom_range(1, 500000)),
                     24'($urandom_range(1, 500000)), 24'($urandom_range(1, 500000)),
                     24'($urandom_range(1, 100000)));
        send_random(200);
    endtask

    initial begin
        geo_layout = 1'b0;
        geo_fx = ARM_RST; geo_fy = ARM_RST; geo_bx = ARM_RST; geo_by = ARM_RST;
        geo_yaw = YAW_RST;
        inv_cached = 1'b0;
        mismatches = 0;
        no_gaps = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_extremes();
        test_geometry_sweep();
        test_backpressure();
        test_random_mix();

        wait_idle();
        if (mismatches == 0 && expected_mix.size() == 0)
            $display("quad_motor_mixer_unit_tb OK");
        else
            $display("quad_motor_mixer_unit_tb NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/qmm_pkg.sv
rtl/qmm_div.sv
rtl/qmm_ctrl.sv
rtl/qmm_datapath.sv
rtl/quad_motor_mixer_unit.sv
test/quad_motor_mixer_unit_tb.sv
